/* hw/rtl/assert_macros.svh */
// Assertion macros for the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define PLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ple_pkg.sv */
// Types and codes shared by the positional list engine modules.
package ple_pkg;

  localparam int CMD_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;
  localparam int EXT_W       = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_EDIT,
    S_DONE
  } ple_state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROT,
    OP_INS,
    OP_REM
  } ple_op_t;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_END  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_END  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_VAL  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SEARCH   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DUMP     = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

/* hw/rtl/ple_cell.sv */
// One list cell: holds a single entry and trades it with its neighbors.
module ple_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int IW         = 4,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  ple_pkg::ple_op_t       op,
  input  logic [IW-1:0]          sel_idx,
  input  logic [IW-1:0]          last_idx,
  input  logic [WORD_WIDTH-1:0]  new_word,
  input  logic [WORD_WIDTH-1:0]  left_word,
  input  logic [WORD_WIDTH-1:0]  right_word,
  input  logic [WORD_WIDTH-1:0]  head_word,
  output logic [WORD_WIDTH-1:0]  word_q
);
  import ple_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [WORD_WIDTH-1:0] word_r, word_nxt;

  // Rotation is circular over the occupied cells: the last one takes the head.
  always_comb begin
    word_nxt = word_r;
    case (op)
      OP_ROT: begin
        if (MY_IDX < last_idx) begin
          word_nxt = right_word;
        end else if (MY_IDX == last_idx) begin
          word_nxt = head_word;
        end
      end
      OP_INS: begin
        if (MY_IDX > sel_idx) begin
          word_nxt = left_word;
        end else if (MY_IDX == sel_idx) begin
          word_nxt = new_word;
        end
      end
      OP_REM: begin
        if (MY_IDX >= sel_idx) begin
          word_nxt = right_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

/* hw/rtl/ple_ctrl.sv */
// Command sequencer: decodes a command, drives the cell row and builds result words.
`include "assert_macros.svh"

module ple_ctrl #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [ple_pkg::CMD_W-1:0]      in_command,
  input  logic signed [ple_pkg::VALUE_W-1:0]    in_value,
  input  logic        [ple_pkg::POS_W-1:0]      in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [ple_pkg::STATUS_W-1:0]   out_status,
  output logic signed [ple_pkg::VALUE_W-1:0]    out_entry_value,
  output logic        [ple_pkg::POS_W-1:0]      out_entry_position,
  output logic        [ple_pkg::COUNT_W-1:0]    out_list_count,
  output logic                                  out_last,
  output ple_pkg::ple_op_t                      cell_op,
  output logic [$clog2(DEPTH)-1:0]              sel_idx,
  output logic [$clog2(DEPTH)-1:0]              last_idx,
  output logic [WORD_WIDTH-1:0]                 new_word,
  input  logic [WORD_WIDTH-1:0]                 head_word
);
  import ple_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ple_state_t state_r, state_nxt;

  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         step_r, step_nxt;
  logic                  found_r, found_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]    res_value_r, res_value_nxt;
  logic [POS_W-1:0]      res_pos_r, res_pos_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_fire, out_free;
  logic [EXT_W-1:0]      value_sx, head_ext;
  logic [VALUE_W-1:0]    head_out;
  logic [PW-1:0]         pos_x, cnt_x, step_pos;
  logic [IW-1:0]         pos_idx, last_step;
  logic                  full, empty, ins_bad, del_bad;
  logic                  is_ins, is_pdel, is_vcmd, hit_now, found_any;
  logic                  walk_end, walk_go, dump_go;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign value_sx  = EXT_W'(in_value);
  assign head_ext  = EXT_W'(head_word);
  assign head_out  = head_ext[VALUE_W-1:0];
  assign pos_x     = PW'(pos_r);
  assign cnt_x     = PW'(count_r);
  assign step_pos  = PW'(step_r) + PW'(1);
  assign pos_idx   = IW'(pos_x - PW'(1));
  assign last_step = IW'(count_r - CW'(1));
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + PW'(1));
  assign del_bad   = (pos_x == '0) || (pos_x > cnt_x);

  assign is_ins    = (cmd_r == CMD_INS_HEAD) || (cmd_r == CMD_INS_END) ||
                     (cmd_r == CMD_INS_POS);
  assign is_pdel   = (cmd_r == CMD_DEL_HEAD) || (cmd_r == CMD_DEL_END) ||
                     (cmd_r == CMD_DEL_POS);
  assign is_vcmd   = (cmd_r == CMD_DEL_VAL) || (cmd_r == CMD_SEARCH);
  assign hit_now   = is_vcmd && !found_r && (head_word == key_r);
  assign found_any = found_r || hit_now;

  // A dump steps only when its word can be loaded; other walks never stall.
  assign walk_end  = (step_r == last_step);
  assign walk_go   = (state_r == S_WALK) && ((cmd_r != CMD_DUMP) || out_free);
  assign dump_go   = walk_go && (cmd_r == CMD_DUMP);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd_r)
          CMD_INS_HEAD, CMD_INS_END: begin
            state_nxt = full ? S_DONE : S_EDIT;
          end
          CMD_INS_POS: begin
            state_nxt = (full || ins_bad) ? S_DONE : S_EDIT;
          end
          CMD_DEL_HEAD, CMD_DEL_END, CMD_DEL_VAL, CMD_SEARCH, CMD_DUMP: begin
            state_nxt = empty ? S_DONE : S_WALK;
          end
          CMD_DEL_POS: begin
            state_nxt = (empty || del_bad) ? S_DONE : S_WALK;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WALK: begin
        if (walk_go && walk_end) begin
          if (cmd_r == CMD_DUMP) begin
            state_nxt = S_IDLE;
          end else if (is_pdel || ((cmd_r == CMD_DEL_VAL) && found_any)) begin
            state_nxt = S_EDIT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_EDIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    cell_op        = OP_HOLD;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_command;
          key_nxt = value_sx[WORD_WIDTH-1:0];
          pos_nxt = in_position;
        end
      end
      S_DECODE: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        res_pos_nxt    = '0;
        step_nxt       = '0;
        found_nxt      = 1'b0;
        case (cmd_r)
          CMD_INS_HEAD: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end
            idx_nxt = '0;
          end
          CMD_INS_END: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end
            idx_nxt = IW'(count_r);
          end
          CMD_INS_POS: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else if (ins_bad) begin
              res_status_nxt = ST_BADPOS;
            end
            idx_nxt = pos_idx;
          end
          CMD_DEL_HEAD: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end
            idx_nxt = '0;
          end
          CMD_DEL_END: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end
            idx_nxt = last_step;
          end
          CMD_DEL_POS: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else if (del_bad) begin
              res_status_nxt = ST_BADPOS;
            end
            idx_nxt = pos_idx;
          end
          CMD_DEL_VAL, CMD_DUMP: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end
          end
          CMD_SEARCH: begin
            if (empty) begin
              res_status_nxt = ST_NOTFOUND;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_WALK: begin
        // Each step rotates the row by one, so the head cell shows entry step_r.
        // A full walk leaves the order as it was.
        if (walk_go) begin
          cell_op  = OP_ROT;
          step_nxt = step_r + IW'(1);
          if (is_pdel && (step_r == idx_r)) begin
            res_value_nxt = head_out;
            res_pos_nxt   = step_pos[POS_W-1:0];
          end
          if (hit_now) begin
            found_nxt     = 1'b1;
            idx_nxt       = step_r;
            res_value_nxt = head_out;
            res_pos_nxt   = step_pos[POS_W-1:0];
          end
          if (walk_end && is_vcmd && !found_any) begin
            res_status_nxt = ST_NOTFOUND;
          end
          if (dump_go) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_value_nxt  = head_out;
            out_pos_nxt    = step_pos[POS_W-1:0];
            out_count_nxt  = cnt_x[COUNT_W-1:0];
            out_last_nxt   = walk_end;
          end
        end
      end
      S_EDIT: begin
        if (is_ins) begin
          cell_op   = OP_INS;
          count_nxt = count_r + CW'(1);
        end else begin
          cell_op   = OP_REM;
          count_nxt = count_r - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_pos_nxt    = res_pos_r;
          out_count_nxt  = cnt_x[COUNT_W-1:0];
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        cell_op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    step_r       <= step_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_value    = out_value_r;
  assign out_entry_position = out_pos_r;
  assign out_list_count     = out_count_r;
  assign out_last           = out_last_r;
  assign sel_idx            = idx_r;
  assign last_idx           = last_step;
  assign new_word           = key_r;

  `PLE_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_r <= FULL_CNT,
    "entry count exceeds the list depth")
  `PLE_ASSERT_IMPL(a_walk_bounds, clk, rst_n, state_r == S_WALK,
    (count_r != '0) && (step_r <= last_step), "walk runs past the occupied cells")
  `PLE_ASSERT_NEXT(a_insert_grows, clk, rst_n, (state_r == S_EDIT) && is_ins,
    count_r == $past(count_r) + CW'(1), "insert did not grow the list by one")
  `PLE_ASSERT_NEXT(a_dump_last, clk, rst_n, dump_go && walk_end,
    out_valid_r && out_last_r, "final dump word is not marked last")

endmodule

/* hw/rtl/positional_list_engine_top.sv */
// Top level of the positional list engine: sequencer plus a row of list cells.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | command, value, position
//   out_    | output    | out_valid/out_ready | status, entry_value, entry_position,
//           |           |                     | list_count, last
//
// Inserts pass through decode and edit to the done state; commands rejected at decode
// and unused codes go from decode straight to done.
// Deletes walk the occupied entries, at most DEPTH of them, and then edit.
// Searches, and deletes by value that miss, skip the edit state.
// A dump gives one word per cycle after decode while out_ready does not stall it.
// The row rotates one cell per walk step past the head, one step per entry.
// Reset empties the list and drops any pending word; cell contents are not cleared.
// A stalled out_ready holds a dump walk and the final word; a new command is taken
// while the last word of the previous one still waits in the output register.
module positional_list_engine_top #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [ple_pkg::CMD_W-1:0]      in_command,
  input  logic signed [ple_pkg::VALUE_W-1:0]    in_value,
  input  logic        [ple_pkg::POS_W-1:0]      in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [ple_pkg::STATUS_W-1:0]   out_status,
  output logic signed [ple_pkg::VALUE_W-1:0]    out_entry_value,
  output logic        [ple_pkg::POS_W-1:0]      out_entry_position,
  output logic        [ple_pkg::COUNT_W-1:0]    out_list_count,
  output logic                                  out_last
);
  import ple_pkg::*;

  localparam int IW = $clog2(DEPTH);

  ple_op_t               cell_op;
  logic [IW-1:0]         sel_idx, last_idx;
  logic [WORD_WIDTH-1:0] new_word, head_word;
  logic [WORD_WIDTH-1:0] cell_word [DEPTH];

  ple_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_value    (out_entry_value),
    .out_entry_position (out_entry_position),
    .out_list_count     (out_list_count),
    .out_last           (out_last),
    .cell_op            (cell_op),
    .sel_idx            (sel_idx),
    .last_idx           (last_idx),
    .new_word           (new_word),
    .head_word          (head_word)
  );

  // Cell 0 is the list head; each cell sees only its two neighbors and the head.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_inner_l
      assign left_w = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_w = cell_word[g];
    end else begin : g_inner_r
      assign right_w = cell_word[g+1];
    end

    ple_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IW         (IW),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .sel_idx    (sel_idx),
      .last_idx   (last_idx),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (head_word),
      .word_q     (cell_word[g])
    );
  end

  assign head_word = cell_word[0];

endmodule

/* tb/positional_list_engine_top_tb.sv */
// Self-checking testbench for the positional list engine: list edits, searches and dumps.
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 120;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } list_word_t;

  // Shadow copy of the list; every accepted command queues the words it must produce.
  class list_shadow;
    logic [VALUE_W-1:0] list_store [LIST_DEPTH];
    int list_count = 0;
    int mismatches = 0;
    list_word_t due_words [$];

    function void queue_word(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] val,
                             int pos, bit fin);
      list_word_t w;
      w.status = st;
      w.value = val;
      w.position = POS_W'(pos);
      w.count = COUNT_W'(list_count);
      w.last = fin;
      due_words.push_back(w);
    endfunction

    function int find_word(logic [VALUE_W-1:0] w);
      for (int i = 0; i < list_count; i++) begin
        if (list_store[i] == w) return i;
      end
      return -1;
    endfunction

    function void put_at(int idx, logic [VALUE_W-1:0] w);
      for (int i = list_count; i > idx; i--) list_store[i] = list_store[i-1];
      list_store[idx] = w;
      list_count++;
    endfunction

    function logic [VALUE_W-1:0] take_at(int idx);
      logic [VALUE_W-1:0] w;
      w = list_store[idx];
      for (int i = idx; i + 1 < list_count; i++) list_store[i] = list_store[i+1];
      list_count--;
      return w;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                               logic [POS_W-1:0] pos);
      int idx;
      logic [VALUE_W-1:0] taken;
      case (cmd)
        CMD_INS_HEAD, CMD_INS_END, CMD_INS_POS: begin
          // A full list is reported before the position is looked at.
          if (list_count >= LIST_DEPTH) begin
            queue_word(ST_FULL, '0, 0, 1'b1);
          end else if (cmd == CMD_INS_POS && (pos == 0 || pos > list_count + 1)) begin
            queue_word(ST_BADPOS, '0, 0, 1'b1);
          end else begin
            if (cmd == CMD_INS_HEAD) idx = 0;
            else if (cmd == CMD_INS_END) idx = list_count;
            else idx = pos - 1;
            put_at(idx, val);
            queue_word(ST_OK, '0, 0, 1'b1);
          end
        end
        CMD_DEL_HEAD, CMD_DEL_END, CMD_DEL_POS: begin
          if (list_count == 0) begin
            queue_word(ST_EMPTY, '0, 0, 1'b1);
          end else if (cmd == CMD_DEL_POS && (pos == 0 || pos > list_count)) begin
            queue_word(ST_BADPOS, '0, 0, 1'b1);
          end else begin
            if (cmd == CMD_DEL_HEAD) idx = 0;
            else if (cmd == CMD_DEL_END) idx = list_count - 1;
            else idx = pos - 1;
            taken = take_at(idx);
            queue_word(ST_OK, taken, idx + 1, 1'b1);
          end
        end
        CMD_DEL_VAL: begin
          if (list_count == 0) begin
            queue_word(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            idx = find_word(val);
            if (idx < 0) begin
              queue_word(ST_NOTFOUND, '0, 0, 1'b1);
            end else begin
              taken = take_at(idx);
              queue_word(ST_OK, taken, idx + 1, 1'b1);
            end
          end
        end
        CMD_SEARCH: begin
          idx = find_word(val);
          if (idx < 0) queue_word(ST_NOTFOUND, '0, 0, 1'b1);
          else queue_word(ST_OK, list_store[idx], idx + 1, 1'b1);
        end
        CMD_DUMP: begin
          if (list_count == 0) begin
            queue_word(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            for (int i = 0; i < list_count; i++) begin
              queue_word(ST_OK, list_store[i], i + 1, i == list_count - 1);
            end
          end
        end
        default: queue_word(ST_OK, '0, 0, 1'b1);
      endcase
    endfunction

    function void check_word(list_word_t got);
      list_word_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected word: status=%0d value=%h pos=%0d count=%0d last=%0b",
                   got.status, got.value, got.position, got.count, got.last);
        end
      end else begin
        want = due_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: word mismatch at %0t", $realtime);
            $display("  expected status=%0d value=%h pos=%0d count=%0d last=%0b",
                     want.status, want.value, want.position, want.count, want.last);
            $display("  actual   status=%0d value=%h pos=%0d count=%0d last=%0b",
                     got.status, got.value, got.position, got.count, got.last);
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [VALUE_W-1:0] out_entry_value;
  logic [POS_W-1:0] out_entry_position;
  logic [COUNT_W-1:0] out_list_count;
  logic out_last;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fill_target = LIST_DEPTH / 2;
  int quiet_cycles = 0;
  logic [VALUE_W-1:0] value_pool [0:7] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                           32'hffff_ffff, 32'h0000_0001, 32'h5555_5555,
                                           32'haaaa_aaaa, 32'h0000_002a};
  list_shadow shadow = new;

  positional_list_engine_top #(
    .DEPTH(LIST_DEPTH),
    .WORD_WIDTH(VALUE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_entry_value(out_entry_value),
    .out_entry_position(out_entry_position),
    .out_list_count(out_list_count),
    .out_last(out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    list_word_t got;
    if (rst_n) begin
      if (in_valid && in_ready) shadow.note_command(in_command, in_value, in_position);
      if (out_valid && out_ready) begin
        got = {out_status, out_entry_value, out_entry_position, out_list_count, out_last};
        shadow.check_word(got);
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("positional_list_engine_top_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_value = val;
    in_position = pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_command();
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0] pos;
    int pick;
    int ins_pct;
    // Steer the fill level toward a moving target so that empty and full lists both occur.
    ins_pct = (shadow.list_count < fill_target) ? 75 : 25;
    if ($urandom_range(0, 99) < ins_pct) begin
      cmd = CMD_W'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 62) cmd = CMD_W'($urandom_range(CMD_DEL_HEAD, CMD_DEL_VAL));
      else if (pick < 80) cmd = CMD_SEARCH;
      else if (pick < 94) cmd = CMD_DUMP;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35 && shadow.list_count > 0) begin
      val = shadow.list_store[$urandom_range(0, shadow.list_count - 1)];
    end else if (pick < 65) begin
      val = value_pool[$urandom_range(0, 7)];
    end else begin
      val = $urandom();
    end
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, shadow.list_count + 2));
    else pos = POS_W'($urandom_range(0, 31));
    send_command(cmd, val, pos);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty list: every delete, search and dump.
    send_command(CMD_DUMP, 32'h0, 5'd0);
    send_command(CMD_DEL_HEAD, 32'h0, 5'd0);
    send_command(CMD_DEL_END, 32'h0, 5'd0);
    send_command(CMD_DEL_POS, 32'h0, 5'd1);
    send_command(CMD_DEL_VAL, 32'h0, 5'd0);
    send_command(CMD_SEARCH, 32'h0, 5'd0);
    // Positional inserts outside 1..count+1, then the edges of the value range.
    send_command(CMD_INS_POS, 32'h1, 5'd0);
    send_command(CMD_INS_POS, 32'h1, 5'd2);
    send_command(CMD_INS_POS, 32'h8000_0000, 5'd1);
    send_command(CMD_INS_HEAD, 32'h7fff_ffff, 5'd31);
    send_command(CMD_INS_END, 32'hffff_ffff, 5'd0);
    send_command(CMD_INS_POS, 32'h0, 5'd4);
    send_command(CMD_INS_POS, 32'h5555_5555, 5'd2);
    send_command(CMD_DUMP, 32'h0, 5'd0);
    send_command(CMD_SEARCH, 32'h0, 5'd0);
    send_command(CMD_SEARCH, 32'h1234_5678, 5'd0);
    send_command(CMD_DEL_VAL, 32'h1234_5678, 5'd0);
    send_command(CMD_DEL_POS, 32'h0, 5'd0);
    send_command(CMD_DEL_POS, 32'h0, 5'd6);
    send_command(CMD_DEL_VAL, 32'hffff_ffff, 5'd0);
    send_command(CMD_DEL_END, 32'h0, 5'd0);
    send_command(CMD_DEL_HEAD, 32'h0, 5'd0);
    send_command(CMD_DEL_POS, 32'h0, 5'd2);
    // Remove the lone remaining word by value.
    send_command(CMD_DEL_VAL, 32'h5555_5555, 5'd0);
    send_command(CMD_SPARE_LO, 32'h0, 5'd0);
    send_command(CMD_SPARE_HI, 32'hffff_ffff, 5'd31);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(0, 3))
            0: fill_target = 0;
            1: fill_target = LIST_DEPTH;
            default: fill_target = $urandom_range(1, LIST_DEPTH - 1);
          endcase
        end
        send_random_command();
      end
      // Hold off new commands until the block has delivered everything owed.
      in_valid = 1'b0;
      while (shadow.due_words.size() != 0) @(negedge clk);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("positional_list_engine_top_tb: PASS");
    end else begin
      $display("positional_list_engine_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine_top.sv
tb/positional_list_engine_top_tb.sv
